// File: design/rcr_pkg.sv
`timescale 1ns / 1ps

package rcr_pkg;

    // Coordinate width and derived result widths
    localparam int COORD_BITS = 16;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int DIST_BITS  = 2 * COORD_BITS + 1;

    // Configuration register indices
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    // Relation codes
    localparam logic [1:0] REL_DISJOINT     = 2'd0;
    localparam logic [1:0] REL_RECT_IN_CIRC = 2'd1;
    localparam logic [1:0] REL_CIRC_IN_RECT = 2'd2;
    localparam logic [1:0] REL_CROSSING     = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_ucoord;
    typedef logic        [SQ_BITS-1:0]    t_sq;
    typedef logic        [DIST_BITS-1:0]  t_dist;

    typedef struct packed {
        t_coord low_x;
        t_coord low_y;
        t_coord high_x;
        t_coord high_y;
    } t_rect;

    typedef struct packed {
        logic [1:0] relation;
        logic       center_inside;
        t_dist      min_dist_sq;
        t_dist      max_dist_sq;
    } t_result;

    typedef struct packed {
        t_coord  center_x;
        t_coord  center_y;
        t_ucoord radius;
    } t_cfg;

endpackage

// File: design/rcr_pipe.sv
`timescale 1ns / 1ps

module rcr_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rcr_pkg::t_cfg   i_cfg,
    input  logic            i_vld,
    input  rcr_pkg::t_rect  i_rect,
    output logic            o_vld,
    output rcr_pkg::t_result o_result
);
    import rcr_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;

    // Stage 1: absolute differences and span tests
    t_ucoord r1_alx, r1_ahx, r1_aly, r1_ahy, r1_rad;
    logic    r1_covx, r1_covy;
    logic    r1_vld;

    function automatic t_ucoord abs_diff(input t_coord a, input t_coord b);
        logic signed [DIFF_BITS-1:0] d;
        logic signed [DIFF_BITS-1:0] m;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        m = d[DIFF_BITS-1] ? -d : d;
        return m[COORD_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        r1_alx  <= abs_diff(i_cfg.center_x, i_rect.low_x);
        r1_ahx  <= abs_diff(i_cfg.center_x, i_rect.high_x);
        r1_aly  <= abs_diff(i_cfg.center_y, i_rect.low_y);
        r1_ahy  <= abs_diff(i_cfg.center_y, i_rect.high_y);
        r1_rad  <= i_cfg.radius;
        r1_covx <= (i_cfg.center_x >= i_rect.low_x) && (i_cfg.center_x <= i_rect.high_x);
        r1_covy <= (i_cfg.center_y >= i_rect.low_y) && (i_cfg.center_y <= i_rect.high_y);
    end

    // Stage 2: squares
    t_sq  r2_slx, r2_shx, r2_sly, r2_shy, r2_r2;
    logic r2_covx, r2_covy;
    logic r2_vld;

    always_ff @(posedge i_clk) begin
        r2_slx  <= SQ_BITS'(r1_alx) * SQ_BITS'(r1_alx);
        r2_shx  <= SQ_BITS'(r1_ahx) * SQ_BITS'(r1_ahx);
        r2_sly  <= SQ_BITS'(r1_aly) * SQ_BITS'(r1_aly);
        r2_shy  <= SQ_BITS'(r1_ahy) * SQ_BITS'(r1_ahy);
        r2_r2   <= SQ_BITS'(r1_rad) * SQ_BITS'(r1_rad);
        r2_covx <= r1_covx;
        r2_covy <= r1_covy;
    end

    // Stage 3: corner sums and edge candidates (all ones when an edge does not cover)
    t_dist r3_c0, r3_c1, r3_c2, r3_c3, r3_ex, r3_ey, r3_r2;
    logic  r3_inside;
    logic  r3_vld;
    t_sq   n_ex, n_ey;

    always_comb begin
        n_ex = (r2_sly < r2_shy) ? r2_sly : r2_shy;
        n_ey = (r2_shx < r2_slx) ? r2_shx : r2_slx;
    end

    always_ff @(posedge i_clk) begin
        r3_c0     <= DIST_BITS'(r2_slx) + DIST_BITS'(r2_sly);
        r3_c1     <= DIST_BITS'(r2_shx) + DIST_BITS'(r2_sly);
        r3_c2     <= DIST_BITS'(r2_shx) + DIST_BITS'(r2_shy);
        r3_c3     <= DIST_BITS'(r2_slx) + DIST_BITS'(r2_shy);
        r3_ex     <= r2_covx ? DIST_BITS'(n_ex) : '1;
        r3_ey     <= r2_covy ? DIST_BITS'(n_ey) : '1;
        r3_r2     <= DIST_BITS'(r2_r2);
        r3_inside <= r2_covx && r2_covy;
    end

    // Stage 4: first level of the min / max tree
    t_dist r4_mx01, r4_mx23, r4_mn01, r4_mn23, r4_emin, r4_r2;
    logic  r4_inside;
    logic  r4_vld;

    always_ff @(posedge i_clk) begin
        r4_mx01   <= (r3_c1 > r3_c0) ? r3_c1 : r3_c0;
        r4_mx23   <= (r3_c3 > r3_c2) ? r3_c3 : r3_c2;
        r4_mn01   <= (r3_c1 < r3_c0) ? r3_c1 : r3_c0;
        r4_mn23   <= (r3_c3 < r3_c2) ? r3_c3 : r3_c2;
        r4_emin   <= (r3_ey < r3_ex) ? r3_ey : r3_ex;
        r4_r2     <= r3_r2;
        r4_inside <= r3_inside;
    end

    // Stage 5: corner max and corner min
    t_dist r5_mx, r5_mnc, r5_emin, r5_r2;
    logic  r5_inside;
    logic  r5_vld;

    always_ff @(posedge i_clk) begin
        r5_mx     <= (r4_mx23 > r4_mx01) ? r4_mx23 : r4_mx01;
        r5_mnc    <= (r4_mn23 < r4_mn01) ? r4_mn23 : r4_mn01;
        r5_emin   <= r4_emin;
        r5_r2     <= r4_r2;
        r5_inside <= r4_inside;
    end

    // Stage 6: final minimum and classification; min > r2 iff both parts exceed it
    logic  n_lt, n_gt;
    t_dist n_mn;
    logic [1:0] n_rel;
    t_result r6_res;
    logic    r6_vld;

    always_comb begin
        n_mn = (r5_emin < r5_mnc) ? r5_emin : r5_mnc;
        n_lt = r5_mx < r5_r2;
        n_gt = (r5_mnc > r5_r2) && (r5_emin > r5_r2);
        if (n_lt) begin
            n_rel = REL_RECT_IN_CIRC;
        end else if (n_gt) begin
            n_rel = r5_inside ? REL_CIRC_IN_RECT : REL_DISJOINT;
        end else begin
            n_rel = REL_CROSSING;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_res.relation      <= n_rel;
        r6_res.center_inside <= r5_inside;
        r6_res.min_dist_sq   <= n_mn;
        r6_res.max_dist_sq   <= r5_mx;
    end

    // Valid bits travelling with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    assign o_vld    = r6_vld;
    assign o_result = r6_res;

endmodule

// File: design/rect_circle_relation.sv
`timescale 1ns / 1ps

// Channel     Direction  Handshake                      Payload
// item        in         start & !busy                  i_rect   (t_rect)
// result      out        o_res_strobe, one cycle        o_result (t_result)
// config      in         i_cfg_valid & o_cfg_ready      i_cfg_index, i_cfg_data
//
// Six register stages: the result strobe is the valid bit of the last stage and
// travels with the item's data; one item per cycle sustained.
// Stage depth is set by the 16x16 squarers and the 33-bit compares of the min / max tree.
// busy stays low, so a new item can be started every cycle.
// Synchronous active-low reset clears the valid bits and sets centre 0, radius 1.
// The receiver cannot hold results off, so nothing in the pipeline ever stalls.

module rect_circle_relation (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rcr_pkg::t_rect    i_rect,
    output logic              o_res_strobe,
    output rcr_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [rcr_pkg::COORD_BITS-1:0] i_cfg_data
);
    import rcr_pkg::*;

    t_cfg r_cfg;
    logic n_start;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.radius   <= t_ucoord'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                REG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                REG_RADIUS:   r_cfg.radius   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;
    assign n_start     = start && !busy;

    rcr_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_vld    (n_start),
        .i_rect   (i_rect),
        .o_vld    (o_res_strobe),
        .o_result (o_result)
    );

endmodule
